/* hw/rtl/tws_pkg.sv */
// shared types and constants of the texture wrap sampler
package tws_pkg;

	localparam int COORD_W   = 16;
	localparam int TEXEL_W   = 8;
	localparam int CFG_W     = 9;
	localparam int MODE_W    = 2;
	localparam int REG_IDX_W = 2;
	localparam int DIV_W     = 10;
	localparam int DIV_STEPS = 8;
	localparam int DIV_CNT_W = 3;

	localparam logic [MODE_W-1:0] MODE_CLAMP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODE = 2'd2;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ROW,
		ST_COL,
		ST_READ,
		ST_LOAD
	} tws_state_t;

	typedef struct packed {
		logic accept_write;
		logic accept_sample;
		logic div_start;
		logic div_sel_col;
		logic cap_row;
		logic cap_col;
		logic rd_en;
		logic out_load;
	} tws_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} tws_status_t;

endpackage

/* hw/rtl/tws_div.sv */
// iterative remainder unit, two restoring steps per cycle
module tws_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tws_pkg::COORD_W-1:0]   dividend,
	input  logic [tws_pkg::DIV_W-1:0]     divisor,
	output logic                          busy,
	output logic                          done,
	output logic [tws_pkg::DIV_W-1:0]     rem
);

	logic                           run_q;
	logic                           done_q;
	logic [tws_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [tws_pkg::COORD_W-1:0]    coord_q;
	logic [tws_pkg::DIV_W-1:0]      rem_q;
	logic [tws_pkg::DIV_W-1:0]      d_q;
	logic [tws_pkg::DIV_W:0]        r1;
	logic [tws_pkg::DIV_W:0]        r2;

	always_comb begin
		r1 = {rem_q, coord_q[tws_pkg::COORD_W-1]};
		if (r1 >= {1'b0, d_q}) begin
			r1 = r1 - {1'b0, d_q};
		end
		r2 = {r1[tws_pkg::DIV_W-1:0], coord_q[tws_pkg::COORD_W-2]};
		if (r2 >= {1'b0, d_q}) begin
			r2 = r2 - {1'b0, d_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= tws_pkg::DIV_CNT_W'(tws_pkg::DIV_STEPS - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - tws_pkg::DIV_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			coord_q <= dividend;
			rem_q   <= '0;
			d_q     <= divisor;
		end else if (run_q) begin
			coord_q <= {coord_q[tws_pkg::COORD_W-3:0], 2'b00};
			rem_q   <= r2[tws_pkg::DIV_W-1:0];
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* hw/rtl/tws_datapath.sv */
// config registers, coordinate wrap, texel store and output register
module tws_datapath #(
	parameter int TEX_DIM = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tws_pkg::tws_cmd_t               cmd,
	output tws_pkg::tws_status_t            status,
	input  logic [tws_pkg::COORD_W-1:0]     sample_row,
	input  logic [tws_pkg::COORD_W-1:0]     sample_col,
	input  logic [tws_pkg::TEXEL_W-1:0]     texel_in,
	input  logic                            cfg_we,
	input  logic [tws_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [tws_pkg::CFG_W-1:0]       cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tws_pkg::TEXEL_W-1:0]     texel_out
);

	localparam int IDX_W     = (TEX_DIM > 1) ? $clog2(TEX_DIM) : 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MEM_DEPTH = 2 ** ADDR_W;

	logic [tws_pkg::CFG_W-1:0]    tex_rows_q;
	logic [tws_pkg::CFG_W-1:0]    tex_cols_q;
	logic [tws_pkg::MODE_W-1:0]   wrap_mode_q;

	logic [tws_pkg::COORD_W-1:0]  row_q;
	logic [tws_pkg::COORD_W-1:0]  col_q;
	logic [tws_pkg::CFG_W-1:0]    rows_eff_q;
	logic [tws_pkg::CFG_W-1:0]    cols_eff_q;
	logic [tws_pkg::MODE_W-1:0]   mode_q;
	logic [IDX_W-1:0]             row_idx_q;
	logic [IDX_W-1:0]             col_idx_q;

	logic [tws_pkg::CFG_W-1:0]    rows_eff;
	logic [tws_pkg::CFG_W-1:0]    cols_eff;
	logic [tws_pkg::COORD_W-1:0]  div_dividend;
	logic [tws_pkg::CFG_W-1:0]    div_size;
	logic [tws_pkg::DIV_W-1:0]    div_divisor;
	logic [tws_pkg::DIV_W-1:0]    div_rem;
	logic [tws_pkg::DIV_W-1:0]    wrapped;
	logic                         div_busy;
	logic                         div_done;
	logic                         wr_in_range;

	logic [tws_pkg::TEXEL_W-1:0]  mem [MEM_DEPTH];
	logic [tws_pkg::TEXEL_W-1:0]  rd_data_q;
	logic                         out_valid_q;
	logic [tws_pkg::TEXEL_W-1:0]  texel_out_q;

	function automatic logic [tws_pkg::CFG_W-1:0] eff_size(input logic [tws_pkg::CFG_W-1:0] s);
		logic [tws_pkg::CFG_W-1:0] e;
		e = s;
		if (s == '0) begin
			e = tws_pkg::CFG_W'(1);
		end else if (32'(s) > 32'(TEX_DIM)) begin
			e = tws_pkg::CFG_W'(TEX_DIM);
		end
		return e;
	endfunction

	function automatic logic [tws_pkg::DIV_W-1:0] wrap_coord(
		input logic [tws_pkg::MODE_W-1:0]  mode,
		input logic [tws_pkg::COORD_W-1:0] c,
		input logic [tws_pkg::CFG_W-1:0]   size,
		input logic [tws_pkg::DIV_W-1:0]   r
	);
		logic [tws_pkg::DIV_W-1:0] sz;
		logic [tws_pkg::DIV_W-1:0] res;
		sz = {1'b0, size};
		case (mode)
			tws_pkg::MODE_REPEAT: begin
				res = r;
			end
			tws_pkg::MODE_MIRROR: begin
				res = (r < sz) ? r : ({size, 1'b0} - tws_pkg::DIV_W'(1) - r);
			end
			default: begin
				res = (c < tws_pkg::COORD_W'(size)) ? c[tws_pkg::DIV_W-1:0]
					: (sz - tws_pkg::DIV_W'(1));
			end
		endcase
		return res;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_rows_q  <= tws_pkg::CFG_W'(1);
			tex_cols_q  <= tws_pkg::CFG_W'(1);
			wrap_mode_q <= tws_pkg::MODE_CLAMP;
		end else if (cfg_we) begin
			case (cfg_index)
				tws_pkg::REG_ROWS: tex_rows_q  <= cfg_data;
				tws_pkg::REG_COLS: tex_cols_q  <= cfg_data;
				tws_pkg::REG_MODE: wrap_mode_q <= cfg_data[tws_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rows_eff     = eff_size(tex_rows_q);
		cols_eff     = eff_size(tex_cols_q);
		div_dividend = cmd.div_sel_col ? col_q : row_q;
		div_size     = cmd.div_sel_col ? cols_eff_q : rows_eff_q;
		div_divisor  = (mode_q == tws_pkg::MODE_MIRROR) ? {div_size, 1'b0} : {1'b0, div_size};
		wrapped      = wrap_coord(mode_q, cmd.cap_col ? col_q : row_q,
			cmd.cap_col ? cols_eff_q : rows_eff_q, div_rem);
		wr_in_range  = (32'(sample_row) < 32'(TEX_DIM)) && (32'(sample_col) < 32'(TEX_DIM));
	end

	tws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem)
	);

	// sample word and wrapped indices
	always_ff @(posedge clk) begin
		if (cmd.accept_sample) begin
			row_q      <= sample_row;
			col_q      <= sample_col;
			rows_eff_q <= rows_eff;
			cols_eff_q <= cols_eff;
			mode_q     <= wrap_mode_q;
		end
		if (cmd.cap_row) begin
			row_idx_q <= IDX_W'(wrapped);
		end
		if (cmd.cap_col) begin
			col_idx_q <= IDX_W'(wrapped);
		end
	end

	// texel store
	always_ff @(posedge clk) begin
		if (cmd.accept_write && wr_in_range) begin
			mem[{sample_row[IDX_W-1:0], sample_col[IDX_W-1:0]}] <= texel_in;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[{row_idx_q, col_idx_q}];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			texel_out_q <= rd_data_q;
		end
	end

	assign status.div_busy = div_busy;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign texel_out       = texel_out_q;

endmodule

/* hw/rtl/tws_ctrl.sv */
// controller state machine of the texture wrap sampler
module tws_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  tws_pkg::tws_status_t    status,
	output tws_pkg::tws_cmd_t       cmd
);

	tws_pkg::tws_state_t state_q;
	tws_pkg::tws_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tws_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			tws_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (action == tws_pkg::ACT_SAMPLE) begin
						cmd.accept_sample = 1'b1;
						state_nxt         = tws_pkg::ST_START;
					end else begin
						cmd.accept_write = 1'b1;
					end
				end
			end
			tws_pkg::ST_START: begin
				cmd.div_start = 1'b1;
				state_nxt     = tws_pkg::ST_ROW;
			end
			tws_pkg::ST_ROW: begin
				if (status.div_done) begin
					cmd.cap_row     = 1'b1;
					cmd.div_start   = 1'b1;
					cmd.div_sel_col = 1'b1;
					state_nxt       = tws_pkg::ST_COL;
				end
			end
			tws_pkg::ST_COL: begin
				cmd.div_sel_col = 1'b1;
				if (status.div_done) begin
					cmd.cap_col = 1'b1;
					state_nxt   = tws_pkg::ST_READ;
				end
			end
			tws_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = tws_pkg::ST_LOAD;
			end
			tws_pkg::ST_LOAD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = tws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tws_pkg::ST_IDLE;
			end
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start && !status.div_done |-> !status.div_busy)
		else $error("divider started while busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("output overwritten while held");

	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept_sample |=> cmd.div_start && !cmd.div_sel_col)
		else $error("sample word not followed by row division");

	a_read_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> state_q == tws_pkg::ST_LOAD)
		else $error("store read not followed by load");

endmodule

/* hw/rtl/texture_wrap_sampler.sv */
// top level of the texture wrap sampler
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  action, sample_row, sample_col, texel_in
//   out      out  out_valid/out_stall  texel_out
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// a write word stores at once; a write past the store is dropped
// a sample word holds the input until its texel is loaded; after acceptance it passes
//   a start state, two remainder passes (row, column) on the shared divider, a read of
//   the texel store and the load
// the next word is taken while a result waits on out_stall; the load waits for it
// reset clears control and sets config to one row, one column and clamp; the texel store holds nothing until written
module texture_wrap_sampler #(
	parameter int TEX_DIM = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [tws_pkg::COORD_W-1:0]     sample_row,
	input  logic [tws_pkg::COORD_W-1:0]     sample_col,
	input  logic [tws_pkg::TEXEL_W-1:0]     texel_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tws_pkg::TEXEL_W-1:0]     texel_out,
	input  logic                            cfg_we,
	input  logic [tws_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [tws_pkg::CFG_W-1:0]       cfg_data
);

	tws_pkg::tws_cmd_t    cmd;
	tws_pkg::tws_status_t status;

	tws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.status   (status),
		.cmd      (cmd)
	);

	tws_datapath #(
		.TEX_DIM (TEX_DIM)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.sample_row (sample_row),
		.sample_col (sample_col),
		.texel_in   (texel_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.texel_out  (texel_out)
	);

endmodule

/* dv/texture_wrap_sampler_test.sv */
// self-checking testbench of the texture wrap sampler: predicted texels against the block's output
module texture_wrap_sampler_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TEX_DIM = 256;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = 30;
	localparam int DRAIN_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_WORDS = 775;
	localparam int PRINT_LIMIT = 40;
	localparam logic [tws_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = tws_pkg::ACT_WRITE;
	logic [tws_pkg::COORD_W-1:0] sample_row = '0;
	logic [tws_pkg::COORD_W-1:0] sample_col = '0;
	logic [tws_pkg::TEXEL_W-1:0] texel_in = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [tws_pkg::TEXEL_W-1:0] texel_out;
	logic cfg_we = 1'b0;
	logic [tws_pkg::REG_IDX_W-1:0] cfg_index = tws_pkg::REG_ROWS;
	logic [tws_pkg::CFG_W-1:0] cfg_data = '0;

	logic [tws_pkg::TEXEL_W-1:0] texel_mem [TEX_DIM*TEX_DIM];
	bit texel_known [TEX_DIM*TEX_DIM];
	logic [tws_pkg::CFG_W-1:0] rows_reg = 9'd1;
	logic [tws_pkg::CFG_W-1:0] cols_reg = 9'd1;
	logic [tws_pkg::MODE_W-1:0] mode_reg = tws_pkg::MODE_CLAMP;
	logic [tws_pkg::TEXEL_W-1:0] expected_texels [$];
	logic [tws_pkg::TEXEL_W-1:0] want_texel;

	int unsigned mismatch_count = 0;
	int unsigned sent_words = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	texture_wrap_sampler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.sample_row(sample_row),
		.sample_col(sample_col),
		.texel_in(texel_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.texel_out(texel_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned span(input logic [tws_pkg::CFG_W-1:0] s);
		if (s == 0)
			return 1;
		if (s > TEX_DIM)
			return TEX_DIM;
		return s;
	endfunction

	function automatic int unsigned wrap_coord(input int unsigned c, input int unsigned size);
		int unsigned t;
		case (mode_reg)
			tws_pkg::MODE_REPEAT: return c % size;
			tws_pkg::MODE_MIRROR: begin
				t = c % (2 * size);
				return (t < size) ? t : 2 * size - 1 - t;
			end
			default: return (c < size) ? c : size - 1;
		endcase
	endfunction

	function automatic int unsigned texel_addr(input logic [tws_pkg::COORD_W-1:0] row,
			input logic [tws_pkg::COORD_W-1:0] col);
		return wrap_coord(row, span(rows_reg)) * TEX_DIM + wrap_coord(col, span(cols_reg));
	endfunction

	function automatic logic [tws_pkg::COORD_W-1:0] pick_coord(input int unsigned size);
		case ($urandom_range(0, 3))
			0: return tws_pkg::COORD_W'($urandom);
			1: return tws_pkg::COORD_W'($urandom_range(0, 4 * size + 2));
			2: return tws_pkg::COORD_W'(16'hFFFF - $urandom_range(0, 2 * size));
			default: return tws_pkg::COORD_W'($urandom_range(0, size - 1));
		endcase
	endfunction

	function automatic logic [tws_pkg::CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 9'd1;
			1: return 9'd256;
			2: return 9'd0;
			3: return tws_pkg::CFG_W'($urandom_range(257, 511));
			4: return 9'd2;
			default: return tws_pkg::CFG_W'($urandom_range(1, 256));
		endcase
	endfunction

	// receiver: random stalls, or a long hold when asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			if (stall_left == 0 && !rx_calm && $urandom_range(0, 2) == 0)
				stall_left = pick_gap();
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left = stall_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_texels.size() == 0) begin
				report_mismatch($sformatf("texel word %02h with no sample pending", texel_out));
			end else begin
				want_texel = expected_texels.pop_front();
				if (texel_out !== want_texel)
					report_mismatch($sformatf("texel_out %02h, predicted %02h",
						texel_out, want_texel));
			end
		end
	end

	task automatic send_word(input logic act, input logic [tws_pkg::COORD_W-1:0] row,
			input logic [tws_pkg::COORD_W-1:0] col, input logic [tws_pkg::TEXEL_W-1:0] texel);
		int unsigned gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		sample_row <= row;
		sample_col <= col;
		texel_in <= texel;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		sent_words++;
		if (act == tws_pkg::ACT_WRITE) begin
			if (row < TEX_DIM && col < TEX_DIM) begin
				texel_mem[row * TEX_DIM + col] = texel;
				texel_known[row * TEX_DIM + col] = 1'b1;
			end
		end else begin
			expected_texels.push_back(texel_mem[texel_addr(row, col)]);
		end
	endtask

	// fills the wrapped entry first when it holds nothing yet
	task automatic sample_at(input logic [tws_pkg::COORD_W-1:0] row,
			input logic [tws_pkg::COORD_W-1:0] col);
		int unsigned a;
		a = texel_addr(row, col);
		if (!texel_known[a])
			send_word(tws_pkg::ACT_WRITE, tws_pkg::COORD_W'(a / TEX_DIM),
				tws_pkg::COORD_W'(a % TEX_DIM), tws_pkg::TEXEL_W'($urandom));
		send_word(tws_pkg::ACT_SAMPLE, row, col, tws_pkg::TEXEL_W'($urandom));
	endtask

	task automatic wait_idle();
		int unsigned waited;
		in_valid <= 1'b0;
		waited = 0;
		while (expected_texels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_texels.size() != 0) begin
			report_mismatch($sformatf("%0d texel words never arrived", expected_texels.size()));
			expected_texels.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tws_pkg::REG_IDX_W-1:0] idx,
			input logic [tws_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			tws_pkg::REG_ROWS: rows_reg = data;
			tws_pkg::REG_COLS: cols_reg = data;
			tws_pkg::REG_MODE: mode_reg = data[tws_pkg::MODE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [tws_pkg::CFG_W-1:0] rows,
			input logic [tws_pkg::CFG_W-1:0] cols, input logic [tws_pkg::CFG_W-1:0] mode_word);
		wait_idle();
		write_reg(tws_pkg::REG_ROWS, rows);
		write_reg(tws_pkg::REG_COLS, cols);
		write_reg(tws_pkg::REG_MODE, mode_word);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_state();
		send_word(tws_pkg::ACT_WRITE, 16'd0, 16'd0, 8'hA5);
		sample_at(16'd0, 16'd0);
		sample_at(16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_corners();
		set_config(9'd256, 9'd256, tws_pkg::CFG_W'(tws_pkg::MODE_CLAMP));
		send_word(tws_pkg::ACT_WRITE, 16'd255, 16'd255, 8'hFF);
		send_word(tws_pkg::ACT_WRITE, 16'd255, 16'd0, 8'h00);
		send_word(tws_pkg::ACT_WRITE, 16'd0, 16'd255, 8'h5A);
		// writes past the store are dropped
		send_word(tws_pkg::ACT_WRITE, 16'd256, 16'd255, 8'h11);
		send_word(tws_pkg::ACT_WRITE, 16'hFFFF, 16'hFFFF, 8'h22);
		sample_at(16'hFFFF, 16'd0);
		sample_at(16'd0, 16'hFFFF);
		sample_at(16'hFFFF, 16'hFFFF);
		sample_at(16'd255, 16'd255);
	endtask

	task automatic test_special_sizes();
		// zero size acts as one
		set_config(9'd0, 9'd0, tws_pkg::CFG_W'(tws_pkg::MODE_REPEAT));
		sample_at(16'd12345, 16'd999);
		sample_at(16'hFFFF, 16'd1);
		// oversize acts as the full store
		set_config(9'd511, 9'd257, tws_pkg::CFG_W'(tws_pkg::MODE_MIRROR));
		sample_at(16'd256, 16'd511);
		sample_at(16'd512, 16'd767);
		// unused mode acts as clamp, upper data bits ignored
		set_config(9'd5, 9'd3, {7'h7F, MODE_UNUSED});
		sample_at(16'd4, 16'd40000);
		sample_at(16'd9, 16'd2);
	endtask

	task automatic test_random_phases();
		int unsigned phase;
		int unsigned n;
		int unsigned p;
		logic [tws_pkg::CFG_W-1:0] r;
		logic [tws_pkg::CFG_W-1:0] c;
		logic [tws_pkg::CFG_W-1:0] mw;
		logic [tws_pkg::COORD_W-1:0] wr;
		logic [tws_pkg::COORD_W-1:0] wc;
		for (phase = 0; sent_words < RANDOM_WORDS; phase++) begin
			if (phase == 0) begin
				r = 9'd256;
				c = 9'd256;
			end else if (phase == 1) begin
				r = 9'd1;
				c = 9'd1;
			end else begin
				r = pick_size();
				c = pick_size();
			end
			mw = tws_pkg::CFG_W'(phase % 4);
			if ($urandom_range(0, 3) == 0)
				mw[tws_pkg::CFG_W-1:tws_pkg::MODE_W] =
					(tws_pkg::CFG_W-tws_pkg::MODE_W)'($urandom);
			set_config(r, c, mw);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			n = $urandom_range(40, 110);
			repeat (n) begin
				if (sent_words >= RANDOM_WORDS)
					break;
				p = $urandom_range(0, 19);
				if (p < 14) begin
					sample_at(pick_coord(span(rows_reg)), pick_coord(span(cols_reg)));
				end else if (p < 17) begin
					send_word(tws_pkg::ACT_WRITE,
						tws_pkg::COORD_W'($urandom_range(0, TEX_DIM - 1)),
						tws_pkg::COORD_W'($urandom_range(0, TEX_DIM - 1)),
						tws_pkg::TEXEL_W'($urandom));
				end else begin
					// out-of-range writes whose low bits alias the sampled area
					wr = tws_pkg::COORD_W'($urandom_range(0, span(rows_reg) - 1));
					wc = tws_pkg::COORD_W'($urandom_range(0, span(cols_reg) - 1));
					case ($urandom_range(0, 2))
						0: wr[tws_pkg::COORD_W-1:8] = 8'($urandom_range(1, 255));
						1: wc[tws_pkg::COORD_W-1:8] = 8'($urandom_range(1, 255));
						default: begin
							wr[tws_pkg::COORD_W-1:8] = 8'($urandom_range(1, 255));
							wc[tws_pkg::COORD_W-1:8] = 8'($urandom_range(1, 255));
						end
					endcase
					send_word(tws_pkg::ACT_WRITE, wr, wc, tws_pkg::TEXEL_W'($urandom));
				end
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	task automatic test_backpressure();
		set_config(9'd7, 9'd200, tws_pkg::CFG_W'(tws_pkg::MODE_MIRROR));
		tx_calm = 1'b1;
		hold_left = HOLD_CYCLES;
		repeat (12) sample_at(pick_coord(span(rows_reg)), pick_coord(span(cols_reg)));
		tx_calm = 1'b0;
	endtask

	task automatic test_streaming();
		set_config(9'd3, 9'd256, tws_pkg::CFG_W'(tws_pkg::MODE_REPEAT));
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		repeat (30) sample_at(pick_coord(span(rows_reg)), pick_coord(span(cols_reg)));
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_corners();
		test_special_sizes();
		test_random_phases();
		test_backpressure();
		test_streaming();
		wait_idle();
		if (mismatch_count == 0)
			$display("[texture_wrap_sampler] OK");
		else
			$display("[texture_wrap_sampler] ERROR");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("[texture_wrap_sampler] ERROR");
		$finish;
	end

endmodule
